@@ hw/rtl/kfl_pkg.sv @@
`default_nettype none
// ============================================================================
// kfl_pkg: shared types and constants of the keyframe track sampler
// Holds the transaction structs, command and status codes, the key record
// and the back-end state encoding.
// ============================================================================
package kfl_pkg;

    // Default track depth and fixed field widths.
    localparam int MAX_KEYS_DEF = 64;
    localparam int CMD_DEPTH    = 2;
    localparam int OUT_DEPTH    = 2;
    localparam int FRAC_W       = 16;
    localparam int COUNT_W      = 7;

    // Input item kinds.
    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    // One input transaction.
    typedef struct packed {
        logic        kind;
        logic [5:0]  key_index;
        logic [31:0] time_point;
        logic [31:0] value_x;
        logic [31:0] value_y;
        logic [31:0] value_z;
    } in_item_t;

    // One result transaction.
    typedef struct packed {
        logic [31:0] out_x;
        logic [31:0] out_y;
        logic [31:0] out_z;
        logic [5:0]  segment_index;
        logic [1:0]  status;
    } out_item_t;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_INTERP = 2'd0,
        STAT_SINGLE = 2'd1,
        STAT_AFTER  = 2'd2,
        STAT_BEFORE = 2'd3
    } status_t;

    // Command passed from the front end to the back end.
    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_SAMPLE = 1'b1
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t     op;
        logic [5:0]  key_index;
        logic [31:0] time_point;
        logic [31:0] value_x;
        logic [31:0] value_y;
        logic [31:0] value_z;
    } cmd_t;

    // One stored key.
    typedef struct packed {
        logic [31:0] tpos;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } key_t;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_KEY,
        S_FIRST,
        S_SCAN,
        S_DIV,
        S_MUL,
        S_ADD,
        S_PUSH
    } back_state_t;

endpackage
`default_nettype wire

@@ hw/rtl/kfl_fifo.sv @@
`default_nettype none
// ============================================================================
// kfl_fifo: small show-ahead queue
// Holds up to DEPTH entries; the oldest entry is visible while not empty.
// ============================================================================
module kfl_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = kfl_pkg::CMD_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    // Storage write.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/kfl_front.sv @@
`default_nettype none
// ============================================================================
// kfl_front: input side of the sampler
// Holds the key count register, classifies input transactions into load
// and sample commands and drops loads aimed past the end of the track.
// ============================================================================
module kfl_front #(
    parameter int MAX_KEYS = kfl_pkg::MAX_KEYS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [kfl_pkg::COUNT_W-1:0]  cfg_data,
    input  wire logic                         push,
    input  wire kfl_pkg::in_item_t            item,
    output logic                              full,
    output logic                              cmd_push,
    output kfl_pkg::cmd_t                     cmd,
    input  wire logic                         cmd_full,
    output logic [kfl_pkg::COUNT_W-1:0]       key_count
);

    logic [kfl_pkg::COUNT_W-1:0] key_count_reg;
    logic                        slot_ok;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_count_reg <= kfl_pkg::COUNT_W'(1);
        end
        else if (cfg_we)
        begin
            key_count_reg <= cfg_data;
        end
    end

    assign key_count = key_count_reg;
    assign full      = cmd_full;

    // Classification: a load beyond the track depth is accepted and dropped.
    assign slot_ok  = (int'(item.key_index) < MAX_KEYS);
    assign cmd_push = push && !cmd_full && ((item.kind == kfl_pkg::KIND_SAMPLE) || slot_ok);

    always_comb
    begin
        cmd.op         = (item.kind == kfl_pkg::KIND_SAMPLE) ? kfl_pkg::OP_SAMPLE
                                                             : kfl_pkg::OP_LOAD;
        cmd.key_index  = item.key_index;
        cmd.time_point = item.time_point;
        cmd.value_x    = item.value_x;
        cmd.value_y    = item.value_y;
        cmd.value_z    = item.value_z;
    end

endmodule
`default_nettype wire

@@ hw/rtl/kfl_div.sv @@
`default_nettype none
// ============================================================================
// kfl_div: sequential fraction divider
// Computes floor((diff << 16) / den) for diff < den, one quotient bit per
// cycle by restoring division.
// ============================================================================
module kfl_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [31:0]                 diff,
    input  wire logic [31:0]                 den,
    output logic                             done,
    output logic [kfl_pkg::FRAC_W-1:0]       quot
);

    localparam int CNT_W = $clog2(kfl_pkg::FRAC_W);

    logic [31:0]                 rem_reg;
    logic [31:0]                 den_reg;
    logic [kfl_pkg::FRAC_W-1:0]  quot_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [32:0]                 shifted;
    logic                        take;

    // One restoring step: the partial remainder stays below den.
    assign shifted = {rem_reg, 1'b0};
    assign take    = (shifted >= {1'b0, den_reg});

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= diff;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg  <= take ? 32'(shifted - {1'b0, den_reg}) : shifted[31:0];
            quot_reg <= {quot_reg[kfl_pkg::FRAC_W-2:0], take};
        end
    end

    // Step counter and completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(kfl_pkg::FRAC_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule
`default_nettype wire

@@ hw/rtl/kfl_back.sv @@
`default_nettype none
// ============================================================================
// kfl_back: key store and sample sequencer
// Writes keys into the key memory, scans it one key per cycle for the
// segment around the sample time, divides for the fraction and blends the
// three components through one shared multiplier.
// ============================================================================
module kfl_back #(
    parameter int MAX_KEYS = kfl_pkg::MAX_KEYS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire kfl_pkg::cmd_t                cmd,
    input  wire logic                         cmd_empty,
    output logic                              cmd_pop,
    input  wire logic [kfl_pkg::COUNT_W-1:0]  key_count,
    output logic                              out_push,
    output kfl_pkg::out_item_t                out_item,
    input  wire logic                         out_full
);

    localparam int KW = $clog2(MAX_KEYS);

    // Key memory with registered read.
    kfl_pkg::key_t mem [MAX_KEYS];
    kfl_pkg::key_t rd_data_reg;
    kfl_pkg::key_t wr_data;
    logic [KW-1:0] rd_addr;
    logic [KW-1:0] wr_addr;
    logic          mem_we;
    logic [KW+5:0] wr_addr_wide;

    // Sequencer state and datapath registers.
    kfl_pkg::back_state_t       state_reg, state_next;
    kfl_pkg::status_t           status_reg, status_next;
    logic [31:0]                t_reg, t_next;
    logic [KW-1:0]              idx_reg, idx_next;
    logic [KW-1:0]              seg_reg, seg_next;
    kfl_pkg::key_t              prev_reg, prev_next;
    kfl_pkg::key_t              nxt_reg, nxt_next;
    logic [1:0]                 comp_reg, comp_next;
    logic [kfl_pkg::FRAC_W-1:0] f_reg, f_next;
    logic signed [49:0]         prod_reg, prod_next;
    logic [31:0]                res_reg [3];
    logic [31:0]                res_next [3];

    logic [KW-1:0]              last_idx;
    logic                       single;
    logic                       before_first;
    logic                       found;
    logic                       at_last;
    logic                       div_start;
    logic                       div_done;
    logic [kfl_pkg::FRAC_W-1:0] div_quot;
    logic [31:0]                div_diff;
    logic [31:0]                div_den;
    logic [31:0]                v0;
    logic [31:0]                v1;
    logic signed [32:0]         delta;
    logic [KW+5:0]              seg_wide;

    // Effective last key index from the key count register.
    always_comb
    begin
        if (key_count == '0)
        begin
            last_idx = '0;
        end
        else if (int'(key_count) > MAX_KEYS)
        begin
            last_idx = KW'(MAX_KEYS - 1);
        end
        else
        begin
            last_idx = KW'(key_count - kfl_pkg::COUNT_W'(1));
        end
    end

    assign single       = (last_idx == '0);
    assign before_first = (t_reg < rd_data_reg.tpos);
    assign found        = (t_reg < rd_data_reg.tpos);
    assign at_last      = ((idx_reg + KW'(1)) == last_idx);

    assign wr_addr_wide = {{KW{1'b0}}, cmd.key_index};
    assign wr_addr      = wr_addr_wide[KW-1:0];
    assign wr_data      = '{tpos: cmd.time_point, x: cmd.value_x,
                            y: cmd.value_y, z: cmd.value_z};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Fraction divider; the segment bounds give t0 <= t < t1.
    assign div_diff = t_reg - prev_reg.tpos;
    assign div_den  = rd_data_reg.tpos - prev_reg.tpos;

    kfl_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .diff  (div_diff),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Component selection for the blend.
    always_comb
    begin
        case (comp_reg)
            2'd0:
            begin
                v0 = prev_reg.x;
                v1 = nxt_reg.x;
            end
            2'd1:
            begin
                v0 = prev_reg.y;
                v1 = nxt_reg.y;
            end
            default:
            begin
                v0 = prev_reg.z;
                v1 = nxt_reg.z;
            end
        endcase
    end

    assign delta = $signed({v1[31], v1}) - $signed({v0[31], v0});

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            kfl_pkg::S_IDLE:
            begin
                if (!cmd_empty && cmd.op == kfl_pkg::OP_SAMPLE)
                begin
                    state_next = single ? kfl_pkg::S_KEY : kfl_pkg::S_FIRST;
                end
            end
            kfl_pkg::S_KEY:
            begin
                state_next = kfl_pkg::S_PUSH;
            end
            kfl_pkg::S_FIRST:
            begin
                state_next = before_first ? kfl_pkg::S_PUSH : kfl_pkg::S_SCAN;
            end
            kfl_pkg::S_SCAN:
            begin
                if (found)
                begin
                    state_next = kfl_pkg::S_DIV;
                end
                else if (at_last)
                begin
                    state_next = kfl_pkg::S_PUSH;
                end
            end
            kfl_pkg::S_DIV:
            begin
                if (div_done)
                begin
                    state_next = kfl_pkg::S_MUL;
                end
            end
            kfl_pkg::S_MUL:
            begin
                state_next = kfl_pkg::S_ADD;
            end
            kfl_pkg::S_ADD:
            begin
                state_next = (comp_reg == 2'd2) ? kfl_pkg::S_PUSH : kfl_pkg::S_MUL;
            end
            kfl_pkg::S_PUSH:
            begin
                if (!out_full)
                begin
                    state_next = kfl_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = kfl_pkg::S_IDLE;
            end
        endcase
    end

    // Control outputs.
    always_comb
    begin
        cmd_pop   = 1'b0;
        mem_we    = 1'b0;
        div_start = 1'b0;
        out_push  = 1'b0;
        rd_addr   = '0;
        case (state_reg)
            kfl_pkg::S_IDLE:
            begin
                cmd_pop = !cmd_empty;
                mem_we  = !cmd_empty && (cmd.op == kfl_pkg::OP_LOAD);
            end
            kfl_pkg::S_FIRST:
            begin
                rd_addr = KW'(1);
            end
            kfl_pkg::S_SCAN:
            begin
                div_start = found;
                rd_addr   = idx_reg + KW'(2);
            end
            kfl_pkg::S_PUSH:
            begin
                out_push = !out_full;
            end
            default:
            begin
                rd_addr = '0;
            end
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        status_next = status_reg;
        t_next      = t_reg;
        idx_next    = idx_reg;
        seg_next    = seg_reg;
        prev_next   = prev_reg;
        nxt_next    = nxt_reg;
        comp_next   = comp_reg;
        f_next      = f_reg;
        prod_next   = prod_reg;
        res_next    = res_reg;
        case (state_reg)
            kfl_pkg::S_IDLE:
            begin
                t_next      = cmd.time_point;
                seg_next    = '0;
                status_next = kfl_pkg::STAT_SINGLE;
            end
            kfl_pkg::S_KEY:
            begin
                res_next[0] = rd_data_reg.x;
                res_next[1] = rd_data_reg.y;
                res_next[2] = rd_data_reg.z;
            end
            kfl_pkg::S_FIRST:
            begin
                res_next[0] = rd_data_reg.x;
                res_next[1] = rd_data_reg.y;
                res_next[2] = rd_data_reg.z;
                seg_next    = '0;
                status_next = kfl_pkg::STAT_BEFORE;
                prev_next   = rd_data_reg;
                idx_next    = '0;
            end
            kfl_pkg::S_SCAN:
            begin
                if (found)
                begin
                    nxt_next    = rd_data_reg;
                    seg_next    = idx_reg;
                    status_next = kfl_pkg::STAT_INTERP;
                end
                else if (at_last)
                begin
                    res_next[0] = rd_data_reg.x;
                    res_next[1] = rd_data_reg.y;
                    res_next[2] = rd_data_reg.z;
                    seg_next    = last_idx;
                    status_next = kfl_pkg::STAT_AFTER;
                end
                else
                begin
                    prev_next = rd_data_reg;
                    idx_next  = idx_reg + KW'(1);
                end
            end
            kfl_pkg::S_DIV:
            begin
                f_next    = div_quot;
                comp_next = 2'd0;
            end
            kfl_pkg::S_MUL:
            begin
                prod_next = delta * $signed({1'b0, f_reg});
            end
            kfl_pkg::S_ADD:
            begin
                // Arithmetic shift by 16 rounds the product toward minus infinity.
                res_next[comp_reg] = v0 + prod_reg[47:16];
                comp_next          = comp_reg + 2'd1;
            end
            default:
            begin
                comp_next = comp_reg;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kfl_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        t_reg      <= t_next;
        idx_reg    <= idx_next;
        seg_reg    <= seg_next;
        prev_reg   <= prev_next;
        nxt_reg    <= nxt_next;
        comp_reg   <= comp_next;
        f_reg      <= f_next;
        prod_reg   <= prod_next;
        res_reg    <= res_next;
    end

    // Result transaction.
    assign seg_wide = {6'd0, seg_reg};

    always_comb
    begin
        out_item.out_x         = res_reg[0];
        out_item.out_y         = res_reg[1];
        out_item.out_z         = res_reg[2];
        out_item.segment_index = seg_wide[5:0];
        out_item.status        = status_reg;
    end

endmodule
`default_nettype wire

@@ hw/rtl/keyframe_track_lerp_sampler.sv @@
`default_nettype none
// ============================================================================
// keyframe_track_lerp_sampler: keyframe track sampler with linear blending
// Top level: front end, command queue, back end and result queue.
// ============================================================================
// The block stores one track of up to MAX_KEYS keys and answers sample
// transactions with the linearly blended vector of the segment that holds
// the sample time. The back end works on one command at a time. A load
// transaction writes the key memory and gives no result. A single-key
// sample returns the only key, and one that falls before the first key
// returns the first key. Otherwise the scan reads the key memory once per
// cycle, comparing later keys until it finds the segment or ends at or
// past the last key, which it then returns. For a blend the fraction comes
// from a divider that yields one bit per cycle, and one shared multiplier
// blends the three components in turn, each through a multiply state and
// an add state. A result is written into the result queue when the back
// end finishes it, and the back end waits while the result queue is full.
// The two-entry command queue keeps taking transactions while a sample is
// under way, and the two-entry result queue lets the back end finish while
// a result waits to be popped.
// ============================================================================
module keyframe_track_lerp_sampler #(
    parameter int MAX_KEYS  = kfl_pkg::MAX_KEYS_DEF,
    parameter int CMD_DEPTH = kfl_pkg::CMD_DEPTH,
    parameter int OUT_DEPTH = kfl_pkg::OUT_DEPTH
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         key_count_we,
    input  wire logic [kfl_pkg::COUNT_W-1:0]  key_count,
    input  wire logic                         push,
    input  wire kfl_pkg::in_item_t            item,
    output logic                              full,
    input  wire logic                         pop,
    output kfl_pkg::out_item_t                result,
    output logic                              empty
);

    localparam int CMD_W = $bits(kfl_pkg::cmd_t);
    localparam int OUT_W = $bits(kfl_pkg::out_item_t);

    kfl_pkg::cmd_t                cmd_in;
    kfl_pkg::cmd_t                cmd_out;
    logic [CMD_W-1:0]             cmd_rd_data;
    logic                         cmd_push;
    logic                         cmd_full;
    logic                         cmd_empty;
    logic                         cmd_pop;
    logic [kfl_pkg::COUNT_W-1:0]  count_val;
    kfl_pkg::out_item_t           back_item;
    logic                         out_push;
    logic                         out_full;
    logic [OUT_W-1:0]             out_rd_data;

    // Front end: configuration and classification.
    kfl_front #(
        .MAX_KEYS (MAX_KEYS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (key_count_we),
        .cfg_data  (key_count),
        .push      (push),
        .item      (item),
        .full      (full),
        .cmd_push  (cmd_push),
        .cmd       (cmd_in),
        .cmd_full  (cmd_full),
        .key_count (count_val)
    );

    // Command queue between the two halves.
    kfl_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd_in),
        .full    (cmd_full),
        .rd_en   (cmd_pop),
        .rd_data (cmd_rd_data),
        .empty   (cmd_empty)
    );

    assign cmd_out = kfl_pkg::cmd_t'(cmd_rd_data);

    // Back end: key memory, scan, divide and blend.
    kfl_back #(
        .MAX_KEYS (MAX_KEYS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_out),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .key_count (count_val),
        .out_push  (out_push),
        .out_item  (back_item),
        .out_full  (out_full)
    );

    // Result queue.
    kfl_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (out_push),
        .wr_data (back_item),
        .full    (out_full),
        .rd_en   (pop),
        .rd_data (out_rd_data),
        .empty   (empty)
    );

    assign result = kfl_pkg::out_item_t'(out_rd_data);

endmodule
`default_nettype wire
